### rtl/core/block_map_allocator_unit_defines.svh
// ----------------------------------------------------------------------------
// block_map_allocator_unit_defines
// Assertion macros for the allocator RTL (used by bma_ctrl).
// ----------------------------------------------------------------------------
`ifndef BLOCK_MAP_ALLOCATOR_UNIT_DEFINES_SVH
`define BLOCK_MAP_ALLOCATOR_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define BMA_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BMA_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define BMA_ASSERT(label, clk, rst_n, prop, msg)
`define BMA_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

### rtl/core/bma_pkg.sv
// ----------------------------------------------------------------------------
// bma_pkg
// Types, codes and defaults for the block map allocator.
// ----------------------------------------------------------------------------
package bma_pkg;

	localparam int unsigned BANKS_DEF       = 3;
	localparam int unsigned BLOCKS_DEF      = 1024;
	localparam int unsigned BLOCK_BYTES_DEF = 32;

	localparam int unsigned CFG_W     = 11;
	localparam int unsigned CFG_RESET = 1024;

	localparam logic [1:0] KIND_ALLOC = 2'd0;
	localparam logic [1:0] KIND_FREE  = 2'd1;
	localparam logic [1:0] KIND_USAGE = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_READY = 2'd1;
	localparam logic [1:0] ST_RANGE     = 2'd2;
	localparam logic [1:0] ST_NO_SPACE  = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  bank;
		logic [15:0] request_bytes;
		logic [15:0] free_offset;
	} bma_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [14:0] granted_offset;
		logic [6:0]  usage_percent;
	} bma_rsp_t;

	typedef struct packed {
		logic       load;
		logic       mul;
		logic       set_ready;
		logic       scan_start;
		logic       scan_step;
		logic       mark_start;
		logic       free_rd;
		logic       free_len;
		logic       wr_step;
		logic       clr_step;
		logic       div_start;
		logic       res_load;
		logic [1:0] res_code;
		logic       out_load;
	} bma_cmd_t;

	typedef struct packed {
		logic       clr_done;
		logic       bank_bad;
		logic [1:0] kind;
		logic       ready;
		logic       need_zero;
		logic       range_bad;
		logic       scan_found;
		logic       scan_end;
		logic       wr_none;
		logic       wr_last;
		logic       div_done;
		logic       out_free;
	} bma_stat_t;

endpackage

### rtl/core/bma_div.sv
// ----------------------------------------------------------------------------
// bma_div
// Restoring divider, one quotient bit per cycle, for the usage percentage.
// ----------------------------------------------------------------------------
module bma_div #(
	parameter int unsigned DVW = 17,
	parameter int unsigned NW  = 11
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [DVW-1:0] dividend,
	input  logic [NW-1:0]  divisor,
	output logic           done,
	output logic [6:0]     quotient
);
	localparam int unsigned CW = $clog2(DVW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] rem_q;
	logic [DVW-1:0] quo_q;
	logic [NW-1:0] dvs_q;
	logic [NW:0]   rem_sh;
	logic          take;

	assign rem_sh = {rem_q, quo_q[DVW-1]};
	assign take   = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DVW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? NW'(rem_sh - {1'b0, dvs_q}) : NW'(rem_sh);
			quo_q <= {quo_q[DVW-2:0], take};
		end
	end

	// used <= n, so the quotient never passes 100
	assign done     = done_q;
	assign quotient = quo_q[6:0];

endmodule

### rtl/core/bma_dpath.sv
// ----------------------------------------------------------------------------
// bma_dpath
// Map memory, scan and write counters, block-count multiplier and result regs.
// ----------------------------------------------------------------------------
module bma_dpath #(
	parameter int unsigned BANKS       = 3,
	parameter int unsigned BLOCKS      = 1024,
	parameter int unsigned BLOCK_BYTES = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bma_pkg::bma_req_t  req,
	input  logic               cfg_valid,
	input  logic [10:0]        cfg_data,
	input  bma_pkg::bma_cmd_t  cmd,
	output bma_pkg::bma_stat_t st,
	input  logic               rsp_stall,
	output logic               rsp_valid,
	output bma_pkg::bma_rsp_t  rsp
);
	import bma_pkg::*;

	localparam int unsigned IW  = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
	localparam int unsigned NW  = $clog2(BLOCKS + 1);
	localparam int unsigned DEPTH = BANKS * BLOCKS;
	localparam int unsigned AW  = $clog2(DEPTH);
	localparam int unsigned AXW = AW + 2;
	localparam int unsigned DVW = $clog2(BLOCKS * 100 + 1);
	// reciprocal multiply: exact floor(x / BLOCK_BYTES) for x below 2^XW
	localparam int unsigned XW  = 17;
	localparam int unsigned SH  = XW + $clog2(BLOCK_BYTES);
	localparam int unsigned MW  = XW + 1;
	localparam longint unsigned RECIP =
		((64'd1 << SH) + BLOCK_BYTES - 1) / BLOCK_BYTES;
	localparam int unsigned PW  = XW + MW;

	bma_req_t          item_q;
	logic [CFG_W-1:0]  cfg_q;
	logic [NW-1:0]     n_w;
	logic [XW-1:0]     mul_x;
	logic [PW-1:0]     prod_s1;
	logic [15:0]       quot;
	logic [IW-1:0]     idx;
	logic [AXW-1:0]    bank_base;

	logic              ready_q;
	logic [AW-1:0]     clr_q;

	logic [IW-1:0]     pos_q;
	logic [NW-1:0]     rem_q;
	logic              v_s1;
	logic [IW-1:0]     idx_s1;
	logic [NW-1:0]     run_q;
	logic [NW-1:0]     used_q;

	logic [IW-1:0]     wptr_q;
	logic [NW-1:0]     wcnt_q;
	logic [NW-1:0]     wval_q;
	logic [14:0]       granted_q;

	logic [NW-1:0]     mem [DEPTH];
	logic [NW-1:0]     rd_data_q;
	logic              we;
	logic [AW-1:0]     wa;
	logic [NW-1:0]     wd;
	logic [AW-1:0]     ra;

	logic [NW-1:0]     lim;
	logic              found;
	logic              div_done;
	logic [6:0]        div_quot;

	bma_rsp_t          res_q;
	bma_rsp_t          rsp_q;
	logic              rsp_valid_q;

	// scanned table length: zero acts as one, clamp at BLOCKS
	always_comb begin
		if (cfg_q == '0)
			n_w = NW'(1);
		else if (32'(cfg_q) > BLOCKS)
			n_w = NW'(BLOCKS);
		else
			n_w = NW'(cfg_q);
	end

	assign mul_x = (item_q.kind == KIND_ALLOC) ?
		XW'(item_q.request_bytes) + XW'(BLOCK_BYTES - 1) : XW'(item_q.free_offset);
	assign quot      = 16'(prod_s1 >> SH);
	assign idx       = IW'(quot);
	assign bank_base = AXW'(item_q.bank) * AXW'(BLOCKS);
	assign lim       = NW'(BLOCKS) - NW'(idx);
	assign found     = v_s1 && (rd_data_q == '0) && ((17'(run_q) + 17'd1) == 17'(quot));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q       <= CFG_W'(CFG_RESET);
			ready_q     <= 1'b0;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid)
				cfg_q <= cfg_data;
			if (cmd.set_ready)
				ready_q <= 1'b1;
			if (cmd.clr_step)
				clr_q <= clr_q + 1'b1;
			if (cmd.out_load)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			item_q <= req;
		if (cmd.mul)
			prod_s1 <= PW'(mul_x) * PW'(RECIP);

		if (cmd.scan_start) begin
			pos_q  <= IW'(n_w - 1'b1);
			rem_q  <= n_w;
			v_s1   <= 1'b0;
			run_q  <= '0;
			used_q <= '0;
		end else if (cmd.scan_step) begin
			v_s1   <= rem_q != '0;
			idx_s1 <= pos_q;
			if (rem_q != '0) begin
				pos_q <= pos_q - 1'b1;
				rem_q <= rem_q - 1'b1;
			end
			if (v_s1) begin
				run_q <= (rd_data_q == '0) ? run_q + 1'b1 : '0;
				if (rd_data_q != '0)
					used_q <= used_q + 1'b1;
			end
		end

		if (cmd.mark_start) begin
			wptr_q    <= idx_s1;
			wcnt_q    <= NW'(quot);
			wval_q    <= NW'(quot);
			granted_q <= 15'(32'(idx_s1) * BLOCK_BYTES);
		end else if (cmd.free_len) begin
			wptr_q <= idx;
			wcnt_q <= (rd_data_q < lim) ? rd_data_q : lim;
			wval_q <= '0;
		end else if (cmd.wr_step) begin
			wptr_q <= wptr_q + 1'b1;
			wcnt_q <= wcnt_q - 1'b1;
		end

		if (cmd.res_load) begin
			res_q.status         <= cmd.res_code;
			res_q.granted_offset <= (cmd.res_code == ST_OK && item_q.kind == KIND_ALLOC) ?
				granted_q : '0;
			res_q.usage_percent  <= (cmd.res_code == ST_OK && item_q.kind == KIND_USAGE) ?
				div_quot : '0;
		end
		if (cmd.out_load)
			rsp_q <= res_q;
	end

	// map memory: one write and one registered read per cycle
	always_comb begin
		we = cmd.wr_step || cmd.clr_step;
		wa = cmd.clr_step ? clr_q : AW'(bank_base + AXW'(wptr_q));
		wd = cmd.clr_step ? '0 : wval_q;
		ra = cmd.free_rd ? AW'(bank_base + AXW'(idx)) : AW'(bank_base + AXW'(pos_q));
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		rd_data_q <= mem[ra];
	end

	bma_div #(
		.DVW (DVW),
		.NW  (NW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (DVW'(used_q) * DVW'(100)),
		.divisor  (n_w),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_comb begin
		st            = '0;
		st.clr_done   = clr_q == AW'(DEPTH - 1);
		st.bank_bad   = 32'(item_q.bank) >= BANKS;
		st.kind       = item_q.kind;
		st.ready      = ready_q;
		st.need_zero  = quot == '0;
		st.range_bad  = 32'(item_q.free_offset) >= BLOCKS * BLOCK_BYTES;
		st.scan_found = found;
		st.scan_end   = (rem_q == '0) && !v_s1;
		st.wr_none    = wcnt_q == '0;
		st.wr_last    = wcnt_q == NW'(1);
		st.div_done   = div_done;
		st.out_free   = !rsp_valid_q || !rsp_stall;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### rtl/core/bma_ctrl.sv
// ----------------------------------------------------------------------------
// bma_ctrl
// Sequencer for clear, allocate scan/mark, free and usage operations.
// ----------------------------------------------------------------------------
`include "block_map_allocator_unit_defines.svh"

module bma_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	output bma_pkg::bma_cmd_t  cmd,
	input  bma_pkg::bma_stat_t st
);
	import bma_pkg::*;

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_MUL   = 4'd2;
	localparam logic [3:0] S_DEC   = 4'd3;
	localparam logic [3:0] S_SCAN  = 4'd4;
	localparam logic [3:0] S_MARK  = 4'd5;
	localparam logic [3:0] S_FLEN  = 4'd6;
	localparam logic [3:0] S_FCLR  = 4'd7;
	localparam logic [3:0] S_USCAN = 4'd8;
	localparam logic [3:0] S_DIV   = 4'd9;
	localparam logic [3:0] S_DONE  = 4'd10;

	logic [3:0] state_q;
	logic [3:0] nxt;

	always_comb begin
		cmd = '0;
		nxt = state_q;
		unique case (state_q)
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (st.clr_done)
					nxt = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					nxt      = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				nxt     = S_DEC;
			end
			S_DEC: begin
				if (st.bank_bad) begin
					cmd.res_load = 1'b1;
					cmd.res_code = ST_RANGE;
					nxt          = S_DONE;
				end else begin
					unique case (st.kind)
						KIND_ALLOC: begin
							cmd.set_ready = 1'b1;
							if (st.need_zero) begin
								cmd.res_load = 1'b1;
								cmd.res_code = ST_NO_SPACE;
								nxt          = S_DONE;
							end else begin
								cmd.scan_start = 1'b1;
								nxt            = S_SCAN;
							end
						end
						KIND_FREE: begin
							if (!st.ready) begin
								cmd.set_ready = 1'b1;
								cmd.res_load  = 1'b1;
								cmd.res_code  = ST_NOT_READY;
								nxt           = S_DONE;
							end else if (st.range_bad) begin
								cmd.res_load = 1'b1;
								cmd.res_code = ST_RANGE;
								nxt          = S_DONE;
							end else begin
								cmd.free_rd = 1'b1;
								nxt         = S_FLEN;
							end
						end
						KIND_USAGE: begin
							cmd.scan_start = 1'b1;
							nxt            = S_USCAN;
						end
						default: begin
							cmd.res_load = 1'b1;
							cmd.res_code = ST_OK;
							nxt          = S_DONE;
						end
					endcase
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (st.scan_found) begin
					cmd.mark_start = 1'b1;
					nxt            = S_MARK;
				end else if (st.scan_end) begin
					cmd.res_load = 1'b1;
					cmd.res_code = ST_NO_SPACE;
					nxt          = S_DONE;
				end
			end
			S_MARK: begin
				cmd.wr_step = 1'b1;
				if (st.wr_last) begin
					cmd.res_load = 1'b1;
					cmd.res_code = ST_OK;
					nxt          = S_DONE;
				end
			end
			S_FLEN: begin
				cmd.free_len = 1'b1;
				nxt          = S_FCLR;
			end
			S_FCLR: begin
				// freeing a free block clears nothing
				if (st.wr_none) begin
					cmd.res_load = 1'b1;
					cmd.res_code = ST_OK;
					nxt          = S_DONE;
				end else begin
					cmd.wr_step = 1'b1;
					if (st.wr_last) begin
						cmd.res_load = 1'b1;
						cmd.res_code = ST_OK;
						nxt          = S_DONE;
					end
				end
			end
			S_USCAN: begin
				cmd.scan_step = 1'b1;
				if (st.scan_end) begin
					cmd.div_start = 1'b1;
					nxt           = S_DIV;
				end
			end
			S_DIV: begin
				if (st.div_done) begin
					cmd.res_load = 1'b1;
					cmd.res_code = ST_OK;
					nxt          = S_DONE;
				end
			end
			S_DONE: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					nxt          = S_IDLE;
				end
			end
			default: nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_CLR;
		else
			state_q <= nxt;
	end

	assign req_stall = state_q != S_IDLE;

	`BMA_ASSERT(a_accept_to_mul, clk, arst_n, (req_valid && !req_stall) |=> (state_q == S_MUL), "accepted request did not start")
	`BMA_ASSERT(a_done_to_idle, clk, arst_n, (state_q == S_DONE && st.out_free) |=> (state_q == S_IDLE), "result not handed off")
	`BMA_ASSERT(a_clr_blocks, clk, arst_n, (state_q == S_CLR) |-> (req_stall && !cmd.wr_step), "request taken during clear")
	`BMA_ASSERT_NEVER(a_scan_excl, clk, arst_n, st.scan_found && st.scan_end, "scan found and ended together")

endmodule

### rtl/core/block_map_allocator_unit.sv
// ----------------------------------------------------------------------------
// block_map_allocator_unit
// Block-table allocator: BANKS pools of BLOCKS blocks, one request at a time.
// ----------------------------------------------------------------------------
// After reset the map memory is cleared one entry per cycle, all BANKS*BLOCKS
// entries, with req_stall held high; cfg writes are taken at any time. Each
// request then runs alone on the map memory: an allocate scans the table
// one map entry per cycle over the scanned table length and then writes
// each marked block; a free reads the stored run length and clears each
// block of the run; a usage query scans the table and then runs the
// divider, one quotient bit per dividend bit. The response sits in an
// output register, so the next request is taken while it waits.
module block_map_allocator_unit #(
	parameter int unsigned BANKS       = bma_pkg::BANKS_DEF,
	parameter int unsigned BLOCKS      = bma_pkg::BLOCKS_DEF,
	parameter int unsigned BLOCK_BYTES = bma_pkg::BLOCK_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  bma_pkg::bma_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output bma_pkg::bma_rsp_t rsp,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [10:0]       cfg_data
);
	import bma_pkg::*;

	bma_cmd_t  cmd;
	bma_stat_t st;

	assign cfg_ready = 1'b1;

	bma_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.cmd       (cmd),
		.st        (st)
	);

	bma_dpath #(
		.BANKS       (BANKS),
		.BLOCKS      (BLOCKS),
		.BLOCK_BYTES (BLOCK_BYTES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.st        (st),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule
